// ===== rtl/rsi_crossover_signal_core_assert.svh =====
// Assertion macros for the RSI crossover signal core.
// Used by the port checker; expects clk_i and rst_ni in the calling scope.
`ifndef RSI_CROSSOVER_SIGNAL_CORE_ASSERT_SVH
`define RSI_CROSSOVER_SIGNAL_CORE_ASSERT_SVH

// Property that must hold in the same cycle as its condition.
`define RSICS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its condition.
`define RSICS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsics_pkg.sv =====
// Package for the RSI crossover signal core: widths, codes and the
// command and status structs shared by the controller and the datapath.
package rsics_pkg;

  localparam int PRICE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int AVG_BITS    = PRICE_BITS + FRAC_BITS;
  localparam int NUM_BITS    = 64;
  localparam int SUM_BITS    = AVG_BITS + 1;
  localparam int PERIOD_BITS = 8;
  localparam int RSI_BITS    = 15;
  localparam int IDX_BITS    = 9;
  localparam int DATE_BITS   = 32;
  localparam int SIG_BITS    = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 15;

  localparam logic [RSI_BITS-1:0] RSI_FULL  = 15'd25600;
  localparam logic [IDX_BITS-1:0] INDEX_SAT = 9'd257;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET     = 8'd14;
  localparam logic [RSI_BITS-1:0]    OVERBOUGHT_RESET = 15'd17920;
  localparam logic [RSI_BITS-1:0]    OVERSOLD_RESET   = 15'd7680;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OVERBOUGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OVERSOLD   = 2'd2;

  // Trade signal codes.
  localparam logic [SIG_BITS-1:0] SIG_NONE = 2'd0;
  localparam logic [SIG_BITS-1:0] SIG_BUY  = 2'd1;
  localparam logic [SIG_BITS-1:0] SIG_SELL = 2'd2;

  // Operand set loaded into the shared divider.
  typedef enum logic [1:0] {
    DSEL_GAIN,
    DSEL_LOSS,
    DSEL_RSI
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     clear_start;
    logic     take_delta;
    logic     route;
    logic     div_start;
    div_sel_e div_sel;
    logic     write_gain;
    logic     write_loss;
    logic     rsum;
    logic     rsi_full;
    logic     write_rsi;
    logic     commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first;
    logic seed;
    logic last;
    logic smooth;
    logic loss_zero;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/rsics_if.sv =====
// Channel interfaces of the RSI crossover signal core: input items,
// result items and configuration writes. Depends on rsics_pkg.
interface rsics_in_if
  import rsics_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  start_series;
  logic [PRICE_BITS-1:0] close_price;
  logic [DATE_BITS-1:0]  sample_date;

  modport source (output valid, start_series, close_price, sample_date, input ready);
  modport sink   (input valid, start_series, close_price, sample_date, output ready);
endinterface

interface rsics_out_if
  import rsics_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  rsi_valid;
  logic [RSI_BITS-1:0]   rsi_value;
  logic [SIG_BITS-1:0]   trade_signal;
  logic [DATE_BITS-1:0]  signal_date;
  logic [PRICE_BITS-1:0] signal_price;

  modport source (output valid, rsi_valid, rsi_value, trade_signal, signal_date,
                  signal_price, input ready);
  modport sink   (input valid, rsi_valid, rsi_value, trade_signal, signal_date,
                  signal_price, output ready);
endinterface

interface rsics_cfg_if
  import rsics_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/rsics_div.sv =====
// Radix-2 restoring divider shared by the averaging and RSI steps.
// One quotient bit per cycle; depends on rsics_pkg.
module rsics_div
  import rsics_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] dividend_i,
  input  logic [SUM_BITS-1:0] divisor_i,
  output logic                done_o,
  output logic [NUM_BITS-1:0] quotient_o
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [NUM_BITS-1:0] quo_q, quo_d;
  logic [SUM_BITS-1:0] rem_q, rem_d;
  logic [SUM_BITS-1:0] div_q, div_d;
  logic [SUM_BITS:0]   rem_sh;
  logic                fits;

  // One shift-compare-subtract step.
  assign rem_sh = {rem_q, quo_q[NUM_BITS-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d = CNT_BITS'(NUM_BITS);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_BITS'(1));
      quo_d  = {quo_q[NUM_BITS-2:0], fits};
      rem_d  = fits ? SUM_BITS'(rem_sh - {1'b0, div_q}) : rem_sh[SUM_BITS-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/rsics_dpath.sv =====
// Datapath of the RSI crossover signal core: configuration, series state,
// averaging arithmetic, RSI and crossing logic. Depends on rsics_pkg, rsics_div.
module rsics_dpath
  import rsics_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic                     start_series_i,
  input  logic [PRICE_BITS-1:0]    close_price_i,
  input  logic [DATE_BITS-1:0]     sample_date_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output logic                     rsi_valid_o,
  output logic [RSI_BITS-1:0]      rsi_value_o,
  output logic [SIG_BITS-1:0]      trade_signal_o,
  output logic [DATE_BITS-1:0]     signal_date_o,
  output logic [PRICE_BITS-1:0]    signal_price_o
);

  // Configuration registers.
  logic [PERIOD_BITS-1:0] period_q;
  logic [RSI_BITS-1:0]    overbought_q, oversold_q;

  // Captured item.
  logic                  start_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [DATE_BITS-1:0]  date_q;

  // Series state.
  logic [IDX_BITS-1:0]   idx_q;
  logic [PRICE_BITS-1:0] prev_close_q;
  logic [AVG_BITS-1:0]   gain_avg_q, loss_avg_q;
  logic [RSI_BITS-1:0]   prev_rsi_q;
  logic                  holding_q;

  // Working registers.
  logic [PRICE_BITS-1:0] gain_q, loss_q;
  logic [NUM_BITS-1:0]   num_g_q, num_l_q, num_r_q;
  logic [SUM_BITS-1:0]   sum_q;
  logic [RSI_BITS-1:0]   rsi_q;

  // Result register.
  logic                  res_valid_q;
  logic [RSI_BITS-1:0]   res_rsi_q;
  logic [SIG_BITS-1:0]   res_sig_q;
  logic [DATE_BITS-1:0]  res_date_q;
  logic [PRICE_BITS-1:0] res_price_q;

  logic [PERIOD_BITS-1:0] n_eff, n_m1;
  logic                   first, seed, last, smooth;
  logic [AVG_BITS-1:0]    gain_acc, loss_acc;
  logic [AVG_BITS+PERIOD_BITS-1:0] gain_prod, loss_prod;
  logic [AVG_BITS+RSI_BITS-1:0]    rsi_prod;
  logic [NUM_BITS-1:0]    gain_smooth, loss_smooth;
  logic [NUM_BITS-1:0]    div_dividend, div_quotient;
  logic [SUM_BITS-1:0]    div_divisor;
  logic                   div_done;
  logic [RSI_BITS-1:0]    rsi_clamped;
  logic                   buy, sell;
  logic [SIG_BITS-1:0]    sig;

  // Effective period; values below two act as two.
  assign n_eff = (period_q < PERIOD_BITS'(2)) ? PERIOD_BITS'(2) : period_q;
  assign n_m1  = n_eff - 1'b1;

  // Phase of the series, taken from the sample count.
  assign first  = (idx_q == '0);
  assign seed   = !first && (idx_q <= IDX_BITS'(n_eff));
  assign last   = (idx_q == IDX_BITS'(n_eff));
  assign smooth = (idx_q > IDX_BITS'(n_eff));

  // Seeding sums and smoothing numerators; the products are sized to hold every bit.
  assign gain_acc    = gain_avg_q + AVG_BITS'(gain_q);
  assign loss_acc    = loss_avg_q + AVG_BITS'(loss_q);
  assign gain_prod   = gain_avg_q * n_m1;
  assign loss_prod   = loss_avg_q * n_m1;
  assign rsi_prod    = gain_avg_q * RSI_FULL;
  assign gain_smooth = NUM_BITS'(gain_prod) + NUM_BITS'({gain_q, {FRAC_BITS{1'b0}}});
  assign loss_smooth = NUM_BITS'(loss_prod) + NUM_BITS'({loss_q, {FRAC_BITS{1'b0}}});

  // Divider operand selection.
  always_comb begin
    unique case (cmd_i.div_sel)
      DSEL_GAIN: begin
        div_dividend = num_g_q;
        div_divisor  = SUM_BITS'(n_eff);
      end
      DSEL_LOSS: begin
        div_dividend = num_l_q;
        div_divisor  = SUM_BITS'(n_eff);
      end
      DSEL_RSI: begin
        div_dividend = num_r_q;
        div_divisor  = sum_q;
      end
      default: begin
        div_dividend = num_r_q;
        div_divisor  = sum_q;
      end
    endcase
  end

  rsics_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign rsi_clamped = (div_quotient > NUM_BITS'(RSI_FULL)) ? RSI_FULL
                                                           : div_quotient[RSI_BITS-1:0];

  // Threshold crossings; buy is tested first.
  assign buy  = !holding_q && (prev_rsi_q <= oversold_q) && (rsi_q > oversold_q);
  assign sell = holding_q && (prev_rsi_q >= overbought_q) && (rsi_q < overbought_q);

  always_comb begin
    priority if (!smooth) sig = SIG_NONE;
    else if (buy)         sig = SIG_BUY;
    else if (sell)        sig = SIG_SELL;
    else                  sig = SIG_NONE;
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PERIOD_RESET;
      overbought_q <= OVERBOUGHT_RESET;
      oversold_q   <= OVERSOLD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PERIOD)     period_q     <= cfg_wdata_i[PERIOD_BITS-1:0];
      if (cfg_index_i == CFG_OVERBOUGHT) overbought_q <= cfg_wdata_i;
      if (cfg_index_i == CFG_OVERSOLD)   oversold_q   <= cfg_wdata_i;
    end
  end

  // Series state; a new series clears it before its first sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      prev_close_q <= '0;
      gain_avg_q   <= '0;
      loss_avg_q   <= '0;
      prev_rsi_q   <= '0;
      holding_q    <= 1'b0;
    end else begin
      if (cmd_i.clear_start && start_q) begin
        idx_q        <= '0;
        prev_close_q <= '0;
        gain_avg_q   <= '0;
        loss_avg_q   <= '0;
        prev_rsi_q   <= '0;
        holding_q    <= 1'b0;
      end
      if (cmd_i.route && seed) begin
        gain_avg_q <= gain_acc;
        loss_avg_q <= loss_acc;
      end
      if (cmd_i.write_gain) gain_avg_q <= div_quotient[AVG_BITS-1:0];
      if (cmd_i.write_loss) loss_avg_q <= div_quotient[AVG_BITS-1:0];
      if (cmd_i.commit) begin
        prev_close_q <= price_q;
        if (idx_q < INDEX_SAT) idx_q <= idx_q + 1'b1;
        if (smooth) begin
          prev_rsi_q <= rsi_q;
          if (buy) holding_q <= 1'b1;
          else if (sell) holding_q <= 1'b0;
        end
      end
    end
  end

  // Item capture, working registers and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      start_q <= start_series_i;
      price_q <= close_price_i;
      date_q  <= sample_date_i;
    end
    if (cmd_i.take_delta) begin
      if (price_q > prev_close_q) begin
        gain_q <= price_q - prev_close_q;
        loss_q <= '0;
      end else begin
        gain_q <= '0;
        loss_q <= prev_close_q - price_q;
      end
    end
    if (cmd_i.route) begin
      if (seed) begin
        num_g_q <= {gain_acc, {FRAC_BITS{1'b0}}};
        num_l_q <= {loss_acc, {FRAC_BITS{1'b0}}};
      end else begin
        num_g_q <= gain_smooth;
        num_l_q <= loss_smooth;
      end
    end
    if (cmd_i.rsum) begin
      sum_q   <= SUM_BITS'(gain_avg_q) + SUM_BITS'(loss_avg_q);
      num_r_q <= NUM_BITS'(rsi_prod);
    end
    if (cmd_i.rsi_full)  rsi_q <= RSI_FULL;
    if (cmd_i.write_rsi) rsi_q <= rsi_clamped;
    if (cmd_i.commit) begin
      res_valid_q <= smooth;
      res_rsi_q   <= smooth ? rsi_q : '0;
      res_sig_q   <= sig;
      res_date_q  <= (sig != SIG_NONE) ? date_q : '0;
      res_price_q <= (sig != SIG_NONE) ? price_q : '0;
    end
  end

  assign stat_o.first     = first;
  assign stat_o.seed      = seed;
  assign stat_o.last      = last;
  assign stat_o.smooth    = smooth;
  assign stat_o.loss_zero = (loss_avg_q == '0);
  assign stat_o.div_done  = div_done;

  assign rsi_valid_o    = res_valid_q;
  assign rsi_value_o    = res_rsi_q;
  assign trade_signal_o = res_sig_q;
  assign signal_date_o  = res_date_q;
  assign signal_price_o = res_price_q;

endmodule

// ===== rtl/rsics_ctrl.sv =====
// Controller of the RSI crossover signal core: sequences one item through
// the datapath and owns the input and output handshakes. Depends on rsics_pkg.
module rsics_ctrl
  import rsics_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SETUP = 4'd1;
  localparam logic [3:0] ST_DELTA = 4'd2;
  localparam logic [3:0] ST_ROUTE = 4'd3;
  localparam logic [3:0] ST_GDIV  = 4'd4;
  localparam logic [3:0] ST_GWAIT = 4'd5;
  localparam logic [3:0] ST_LDIV  = 4'd6;
  localparam logic [3:0] ST_LWAIT = 4'd7;
  localparam logic [3:0] ST_RSUM  = 4'd8;
  localparam logic [3:0] ST_RDIV  = 4'd9;
  localparam logic [3:0] ST_RWAIT = 4'd10;
  localparam logic [3:0] ST_STORE = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DSEL_GAIN;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.clear_start = 1'b1;
        state_d = ST_DELTA;
      end
      ST_DELTA: begin
        cmd_o.take_delta = 1'b1;
        state_d = ST_ROUTE;
      end
      ST_ROUTE: begin
        cmd_o.route = 1'b1;
        priority if (stat_i.first)               state_d = ST_STORE;
        else if (stat_i.seed && !stat_i.last)    state_d = ST_STORE;
        else                                     state_d = ST_GDIV;
      end
      ST_GDIV: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_GWAIT;
      end
      ST_GWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.write_gain = 1'b1;
          state_d = ST_LDIV;
        end
      end
      ST_LDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DSEL_LOSS;
        state_d = ST_LWAIT;
      end
      ST_LWAIT: begin
        cmd_o.div_sel = DSEL_LOSS;
        if (stat_i.div_done) begin
          cmd_o.write_loss = 1'b1;
          state_d = stat_i.smooth ? ST_RSUM : ST_STORE;
        end
      end
      ST_RSUM: begin
        // Loss average of zero gives the full-scale RSI without a division.
        cmd_o.rsum     = 1'b1;
        cmd_o.rsi_full = stat_i.loss_zero;
        state_d = stat_i.loss_zero ? ST_STORE : ST_RDIV;
      end
      ST_RDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DSEL_RSI;
        state_d = ST_RWAIT;
      end
      ST_RWAIT: begin
        cmd_o.div_sel = DSEL_RSI;
        if (stat_i.div_done) begin
          cmd_o.write_rsi = 1'b1;
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/rsi_crossover_signal_core.sv =====
// Top level of the RSI crossover signal core: joins the controller and the
// datapath to the channels. Depends on rsics_pkg, rsics_if, rsics_ctrl, rsics_dpath.
//
//   channel     dir   handshake      payload
//   in_chan_i   in    valid/ready    start_series, close_price, sample_date
//   out_chan_o  out   valid/ready    rsi_valid, rsi_value, trade_signal,
//                                    signal_date, signal_price
//   cfg_chan_i  in    valid/ready    index, wdata (ready is always high)
//
// From the accept each item runs the setup, delta and route steps and ends with the store step.
// The item that ends seeding and each smoothing item add a gain and a loss division in the
// shared radix-2 divider; a smoothing item then adds the RSI sum and an RSI division (the sum
// alone with a zero loss average). The input reopens in the cycle after the store.
// Reset clears the series state and loads the register defaults; no clearing pass.
// A stalled output holds the next item only at its final store step.
module rsi_crossover_signal_core
  import rsics_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  rsics_in_if.sink    in_chan_i,
  rsics_cfg_if.sink   cfg_chan_i,
  rsics_out_if.source out_chan_o
);

  cmd_t  cmd;
  stat_t stat;

  // Configuration writes are always taken.
  assign cfg_chan_i.ready = 1'b1;

  rsics_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_chan_i.ready),
    .out_valid_o (out_chan_o.valid),
    .out_ready_i (out_chan_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rsics_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .start_series_i (in_chan_i.start_series),
    .close_price_i  (in_chan_i.close_price),
    .sample_date_i  (in_chan_i.sample_date),
    .cfg_we_i       (cfg_chan_i.valid),
    .cfg_index_i    (cfg_chan_i.index),
    .cfg_wdata_i    (cfg_chan_i.wdata),
    .rsi_valid_o    (out_chan_o.rsi_valid),
    .rsi_value_o    (out_chan_o.rsi_value),
    .trade_signal_o (out_chan_o.trade_signal),
    .signal_date_o  (out_chan_o.signal_date),
    .signal_price_o (out_chan_o.signal_price)
  );

endmodule

// ===== rtl/rsics_checker.sv =====
// Port checker for the RSI crossover signal core, bound to the top level.
// Depends on rsics_pkg and rsi_crossover_signal_core_assert.svh.
`include "rsi_crossover_signal_core_assert.svh"

module rsics_checker
  import rsics_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  rsi_valid_i,
  input logic [RSI_BITS-1:0]   rsi_value_i,
  input logic [SIG_BITS-1:0]   trade_signal_i,
  input logic [DATE_BITS-1:0]  signal_date_i,
  input logic [PRICE_BITS-1:0] signal_price_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A trade signal only comes with a computed RSI.
  `RSICS_ASSERT_SAME(a_sig_needs_rsi, out_valid_i && (trade_signal_i != SIG_NONE), rsi_valid_i, "trade signal without valid RSI")

  // Without a valid RSI the value reads zero and no trade is signalled.
  `RSICS_ASSERT_SAME(a_invalid_rsi_zero, out_valid_i && !rsi_valid_i, (rsi_value_i == '0) && (trade_signal_i == SIG_NONE), "invalid RSI carries data")

  // Date and price tags are zero when no trade is signalled.
  `RSICS_ASSERT_SAME(a_no_sig_no_tags, out_valid_i && (trade_signal_i == SIG_NONE), (signal_date_i == '0) && (signal_price_i == '0), "tags set without trade")

  // One item at a time: the input closes once an item is taken.
  `RSICS_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_i, "input ready while an item is in work")

  // No result can appear in the cycle straight after an accept.
  `RSICS_ASSERT_NEXT(a_no_instant_result, in_acc && !(out_valid_i && !out_ready_i), !$rose(out_valid_i), "result rose straight after accept")

endmodule

bind rsi_crossover_signal_core rsics_checker u_rsics_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_chan_i.valid),
  .in_ready_i     (in_chan_i.ready),
  .out_valid_i    (out_chan_o.valid),
  .out_ready_i    (out_chan_o.ready),
  .rsi_valid_i    (out_chan_o.rsi_valid),
  .rsi_value_i    (out_chan_o.rsi_value),
  .trade_signal_i (out_chan_o.trade_signal),
  .signal_date_i  (out_chan_o.signal_date),
  .signal_price_i (out_chan_o.signal_price)
);

// ===== test/tb_rsi_crossover_signal_core.sv =====
// Self-checking testbench for the RSI crossover signal core: directed corner series,
// register changes mid-series, output back-pressure and long random price walks.
// Depends on rsics_pkg, the channel interfaces in rsics_if and the core itself.
`timescale 1ns / 100ps

module tb_rsi_crossover_signal_core;
  import rsics_pkg::*;

  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam longint PRICE_TOP = 64'h0000_0000_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic                  rsi_valid;
    logic [RSI_BITS-1:0]   rsi_value;
    logic [SIG_BITS-1:0]   trade_signal;
    logic [DATE_BITS-1:0]  signal_date;
    logic [PRICE_BITS-1:0] signal_price;
  } rsi_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rsics_in_if  in_if ();
  rsics_cfg_if cfg_if ();
  rsics_out_if out_if ();

  rsi_crossover_signal_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .cfg_chan_i (cfg_if),
    .out_chan_o (out_if)
  );

  // Register copies and series state of the predictor.
  logic [PERIOD_BITS-1:0] reg_period;
  logic [RSI_BITS-1:0]    reg_overbought;
  logic [RSI_BITS-1:0]    reg_oversold;
  logic [IDX_BITS-1:0]    series_count;
  logic [63:0]            last_close;
  logic [63:0]            gain_avg;
  logic [63:0]            loss_avg;
  logic [RSI_BITS-1:0]    last_rsi;
  logic                   in_position;

  rsi_result_t expected_results[$];

  // Shared run state.
  int  error_count     = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  buys_seen       = 0;
  int  sells_seen      = 0;
  int  settings_used   = 0;
  int  hold_out_cycles = 0;
  bit  no_gaps         = 1'b0;

  // Price walk state for the random series.
  longint      walk_price;
  int unsigned walk_scale;
  int          trend_left;
  bit          trend_up;

  // Clock: 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mismatch reporting.
  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
             results_checked, field, got, want);
    error_count++;
  endtask

  function automatic void clear_series_state();
    series_count = '0;
    last_close   = '0;
    gain_avg     = '0;
    loss_avg     = '0;
    last_rsi     = '0;
    in_position  = 1'b0;
  endfunction

  // Predicts the result item for one input item and advances the series state.
  function automatic rsi_result_t predict_result(input logic start,
                                                 input logic [PRICE_BITS-1:0] price_in,
                                                 input logic [DATE_BITS-1:0] date_in);
    logic [63:0]          avg_mask;
    logic [63:0]          n;
    logic [63:0]          price;
    logic [63:0]          gain;
    logic [63:0]          loss;
    logic [63:0]          total;
    logic [63:0]          ratio;
    logic [RSI_BITS-1:0]  rsi;
    logic [SIG_BITS-1:0]  sig;
    logic                 rsi_ok;
    rsi_result_t          res;
    avg_mask = (64'd1 << AVG_BITS) - 64'd1;
    price    = {32'd0, price_in};
    gain     = '0;
    loss     = '0;
    rsi      = '0;
    sig      = SIG_NONE;
    rsi_ok   = 1'b0;
    if (start) clear_series_state();
    n = (reg_period < 8'd2) ? 64'd2 : {56'd0, reg_period};

    if (series_count >= 1) begin
      if (price > last_close) gain = price - last_close;
      else loss = last_close - price;

      if ({55'd0, series_count} <= n) begin
        // Seeding: plain sums, turned into means at the last change of the period.
        gain_avg = (gain_avg + gain) & avg_mask;
        loss_avg = (loss_avg + loss) & avg_mask;
        if ({55'd0, series_count} == n) begin
          gain_avg = ((gain_avg << FRAC_BITS) / n) & avg_mask;
          loss_avg = ((loss_avg << FRAC_BITS) / n) & avg_mask;
        end
      end else begin
        // Wilder smoothing and the RSI itself.
        gain_avg = ((gain_avg * (n - 64'd1) + (gain << FRAC_BITS)) / n) & avg_mask;
        loss_avg = ((loss_avg * (n - 64'd1) + (loss << FRAC_BITS)) / n) & avg_mask;
        total = gain_avg + loss_avg;
        if (loss_avg == 0 || total == 0) begin
          rsi = RSI_FULL;
        end else begin
          ratio = (64'(RSI_FULL) * gain_avg) / total;
          rsi   = (ratio > 64'(RSI_FULL)) ? RSI_FULL : ratio[RSI_BITS-1:0];
        end
        rsi_ok = 1'b1;

        // Buy is tested first; sell only applies while in position.
        if (!in_position && last_rsi <= reg_oversold && rsi > reg_oversold) begin
          sig         = SIG_BUY;
          in_position = 1'b1;
        end else if (in_position && last_rsi >= reg_overbought && rsi < reg_overbought) begin
          sig         = SIG_SELL;
          in_position = 1'b0;
        end
        last_rsi = rsi;
      end
    end

    last_close = price;
    if (series_count < INDEX_SAT) series_count = series_count + 1'b1;

    res.rsi_valid    = rsi_ok;
    res.rsi_value    = rsi;
    res.trade_signal = sig;
    res.signal_date  = (sig != SIG_NONE) ? date_in : '0;
    res.signal_price = (sig != SIG_NONE) ? price_in : '0;
    return res;
  endfunction

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int next_gap(input int long_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < long_pct) return $urandom_range(20, 80);
    if (r < 55) return 0;
    return $urandom_range(1, 4);
  endfunction

  function automatic void new_series();
    walk_price = longint'($urandom);
    walk_scale = 32'd1 << $urandom_range(0, 20);
    trend_left = 0;
  endfunction

  // Next price of a trending walk, with the odd jump to the extremes or anywhere.
  function automatic logic [PRICE_BITS-1:0] next_walk_price();
    int unsigned pick;
    longint      stepv;
    pick = $urandom_range(0, 99);
    if (trend_left == 0) begin
      trend_up   = 1'($urandom_range(0, 1));
      trend_left = $urandom_range(2, 20);
    end
    trend_left--;
    stepv = longint'($urandom_range(0, walk_scale));
    if (pick < 2) begin
      walk_price = 0;
    end else if (pick < 4) begin
      walk_price = PRICE_TOP;
    end else if (pick < 6) begin
      walk_price = longint'($urandom);
    end else begin
      if (pick < 24) walk_price = trend_up ? walk_price - stepv : walk_price + stepv;
      else walk_price = trend_up ? walk_price + stepv : walk_price - stepv;
      if (walk_price < 0) walk_price = 0;
      if (walk_price > PRICE_TOP) walk_price = PRICE_TOP;
    end
    return walk_price[PRICE_BITS-1:0];
  endfunction

  // Offers one price item and records its expected result once accepted.
  task automatic send_item(input logic start, input logic [PRICE_BITS-1:0] price,
                           input logic [DATE_BITS-1:0] date);
    int gap;
    gap = next_gap(4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.start_series <= start;
    in_if.close_price  <= price;
    in_if.sample_date  <= date;
    do @(posedge clk_i); while (!in_if.ready);
    expected_results = {expected_results, predict_result(start, price, date)};
    items_sent++;
  endtask

  // Stops offering items and waits until every expected result has been taken.
  task automatic wait_block_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_PERIOD:     reg_period     = data[PERIOD_BITS-1:0];
      CFG_OVERBOUGHT: reg_overbought = data[RSI_BITS-1:0];
      CFG_OVERSOLD:   reg_oversold   = data[RSI_BITS-1:0];
      default: ;
    endcase
  endtask

  // Writes all three registers (and on request the unused index) while the block is idle;
  // the period carries random junk in the unused upper bits of the write data.
  task automatic apply_settings(input logic [PERIOD_BITS-1:0] period,
                                input logic [RSI_BITS-1:0] overbought,
                                input logic [RSI_BITS-1:0] oversold,
                                input bit poke_unused);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom);
    wait_block_idle();
    write_reg(CFG_PERIOD, {junk[CFG_DATA_BITS-1:PERIOD_BITS], period});
    write_reg(CFG_OVERBOUGHT, overbought);
    write_reg(CFG_OVERSOLD, oversold);
    if (poke_unused) write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // First sample, zero changes, full-scale jumps, buy then sell, restart and
  // a flat series, with a period of zero that must act as two.
  task automatic test_series_corners();
    apply_settings(8'd0, OVERBOUGHT_RESET, OVERSOLD_RESET, 1'b0);
    send_item(1'b1, 32'd100, 32'd0);
    send_item(1'b0, 32'd100, 32'd1);
    send_item(1'b0, 32'hFFFF_FFFF, 32'd2);
    send_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 32'd0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'd0, 32'h5555_AAAA);
    send_item(1'b1, 32'hFFFF_FFFF, 32'hAAAA_5555);
    send_item(1'b0, 32'hFFFF_FFFF, 32'd7);
    send_item(1'b0, 32'hFFFF_FFFF, 32'd8);
    send_item(1'b0, 32'hFFFF_FFFF, 32'd9);
  endtask

  // Period changes without a restart: one that acts as two, and a drop from
  // fourteen to three half-way through seeding, which jumps straight to smoothing.
  task automatic test_period_changes();
    apply_settings(8'd1, OVERBOUGHT_RESET, OVERSOLD_RESET, 1'b1);
    send_item(1'b0, 32'd1000, 32'd10);
    send_item(1'b0, 32'd5000, 32'd11);
    send_item(1'b0, 32'd200, 32'd12);
    apply_settings(PERIOD_RESET, OVERBOUGHT_RESET, OVERSOLD_RESET, 1'b0);
    send_item(1'b1, 32'd4000, 32'd13);
    send_item(1'b0, 32'd4100, 32'd14);
    send_item(1'b0, 32'd3900, 32'd15);
    send_item(1'b0, 32'd4300, 32'd16);
    send_item(1'b0, 32'd4250, 32'd17);
    apply_settings(8'd3, OVERBOUGHT_RESET, OVERSOLD_RESET, 1'b0);
    send_item(1'b0, 32'd4600, 32'd18);
    send_item(1'b0, 32'd3000, 32'd19);
    send_item(1'b0, 32'd3500, 32'd20);
  endtask

  // Thresholds at the register's top (no crossing possible) and at zero.
  task automatic test_threshold_extremes();
    apply_settings(8'd2, 15'h7FFF, 15'h7FFF, 1'b0);
    send_item(1'b1, 32'd50, 32'd21);
    send_item(1'b0, 32'd90, 32'd22);
    send_item(1'b0, 32'd60, 32'd23);
    send_item(1'b0, 32'd80, 32'd24);
    apply_settings(8'd2, 15'd0, 15'd0, 1'b0);
    send_item(1'b1, 32'd80, 32'd25);
    send_item(1'b0, 32'd70, 32'd26);
    send_item(1'b0, 32'd75, 32'd27);
    send_item(1'b0, 32'd10, 32'd28);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // result register fills and the block stops accepting input.
  task automatic test_output_backpressure();
    apply_settings(8'd2, OVERBOUGHT_RESET, OVERSOLD_RESET, 1'b0);
    new_series();
    hold_out_cycles = 3000;
    no_gaps = 1'b1;
    for (int k = 0; k < 24; k++) send_item(k == 0, next_walk_price(), $urandom);
    no_gaps = 1'b0;
  endtask

  // One phase of random trending series under one register setting.
  task automatic run_random_phase(input logic [PERIOD_BITS-1:0] period,
                                  input logic [RSI_BITS-1:0] overbought,
                                  input logic [RSI_BITS-1:0] oversold,
                                  input int count, input bit quiet);
    bit start;
    apply_settings(period, overbought, oversold, 1'($urandom_range(0, 1)));
    no_gaps = quiet;
    for (int k = 0; k < count; k++) begin
      start = (k == 0) || ($urandom_range(0, 299) == 0);
      if (start) new_series();
      send_item(start, next_walk_price(), $urandom);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_settings();
    run_random_phase(PERIOD_RESET, OVERBOUGHT_RESET, OVERSOLD_RESET, 150, 1'b0);
    run_random_phase(8'd2, RSI_FULL, 15'd0, 150, 1'b1);
    run_random_phase(8'd255, RSI_BITS'($urandom_range(0, RSI_FULL)),
                     RSI_BITS'($urandom_range(0, RSI_FULL)), 330, 1'b0);
    run_random_phase(8'd3, 15'h7FFF, RSI_FULL, 100, 1'b0);
    for (int p = 0; p < 4; p++)
      run_random_phase(PERIOD_BITS'($urandom_range(2, 40)),
                       RSI_BITS'($urandom_range(0, RSI_FULL)),
                       RSI_BITS'($urandom_range(0, RSI_FULL)), 120, p == 2);
  endtask

  task automatic finish_run();
    wait_block_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d price items under %0d register settings, %0d results checked.",
             items_sent, settings_used, results_checked);
    $display("Trade signals observed: %0d buy, %0d sell.", buys_seen, sells_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  endtask

  // Result side: checks each accepted result and drives ready with random gaps.
  initial begin : result_checker
    rsi_result_t got;
    rsi_result_t want;
    int          run_left;
    logic        ready_next;
    run_left   = 0;
    ready_next = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got = '{rsi_valid: out_if.rsi_valid, rsi_value: out_if.rsi_value,
                trade_signal: out_if.trade_signal, signal_date: out_if.signal_date,
                signal_price: out_if.signal_price};
        if (expected_results.size() == 0) begin
          report_mismatch("item with nothing expected", 64'(got), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.rsi_valid !== want.rsi_valid)
            report_mismatch("rsi_valid", 64'(got.rsi_valid), 64'(want.rsi_valid));
          if (got.rsi_value !== want.rsi_value)
            report_mismatch("rsi_value", 64'(got.rsi_value), 64'(want.rsi_value));
          if (got.trade_signal !== want.trade_signal)
            report_mismatch("trade_signal", 64'(got.trade_signal), 64'(want.trade_signal));
          if (got.signal_date !== want.signal_date)
            report_mismatch("signal_date", 64'(got.signal_date), 64'(want.signal_date));
          if (got.signal_price !== want.signal_price)
            report_mismatch("signal_price", 64'(got.signal_price), 64'(want.signal_price));
        end
        if (got.trade_signal == SIG_BUY) buys_seen++;
        if (got.trade_signal == SIG_SELL) sells_seen++;
        results_checked++;
      end

      // Long hold first, then quiet stretches, then random runs and gaps.
      if (hold_out_cycles > 0) begin
        hold_out_cycles--;
        ready_next = 1'b0;
        run_left   = 0;
      end else if (no_gaps) begin
        ready_next = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else if (ready_next) begin
        run_left = next_gap(3);
        if (run_left > 0) begin
          ready_next = 1'b0;
          run_left--;
        end else begin
          run_left = $urandom_range(0, 12);
        end
      end else begin
        ready_next = 1'b1;
        run_left   = $urandom_range(0, 12);
      end
      out_if.ready <= ready_next;
    end
  end

  // Main sequence: reset, then each test in turn.
  initial begin : test_sequence
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.start_series <= 1'b0;
    in_if.close_price  <= '0;
    in_if.sample_date  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_PERIOD;
    cfg_if.wdata       <= '0;
    reg_period     = PERIOD_RESET;
    reg_overbought = OVERBOUGHT_RESET;
    reg_oversold   = OVERSOLD_RESET;
    clear_series_state();
    new_series();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_series_corners();
    test_period_changes();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_settings();
    finish_run();
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #24_000_000;
    $display("TIMEOUT: %0d results still outstanding", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rsics_pkg.sv
rtl/rsics_if.sv
rtl/rsics_div.sv
rtl/rsics_dpath.sv
rtl/rsics_ctrl.sv
rtl/rsi_crossover_signal_core.sv
rtl/rsics_checker.sv
test/tb_rsi_crossover_signal_core.sv
